// ===== hw/rtl/rbwn_pkg.sv =====
// Shared constants and types for the raw black/white normalize block.
`default_nettype none

package rbwn_pkg;

   localparam int COUNT_BITS     = 16;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;
   localparam int LEVEL_BITS     = 20;
   localparam int QUO_BITS       = LEVEL_BITS + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [QUO_BITS-1:0]   POS_LIMIT = 21'd524287;
   localparam logic [QUO_BITS-1:0]   NEG_LIMIT = 21'd524288;

   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX_CODE = 20'h7FFFF;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MIN_CODE = 20'h80000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BLACK_EVEN  = 3'd0,
      CSR_BLACK_ODD   = 3'd1,
      CSR_WHITE_LEVEL = 3'd2,
      CSR_CROP_LEFT   = 3'd3,
      CSR_CROP_TOP    = 3'd4,
      CSR_OUT_WIDTH   = 3'd5,
      CSR_OUT_HEIGHT  = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic neg;
      logic empty;
      logic over;
      logic line_done;
      logic frame_done;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rbwn_channels.sv =====
// Request and response channel interfaces of the raw black/white normalize block.
`default_nettype none

interface rbwn_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample;
   logic        start_of_frame;
   logic        end_of_line;

   modport source (output valid, output sample, output start_of_frame,
                   output end_of_line, input ready);
   modport sink   (input valid, input sample, input start_of_frame,
                   input end_of_line, output ready);
endinterface

interface rbwn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [19:0] level;
   logic               out_of_range;
   logic               line_done;
   logic               frame_done;

   modport source (output valid, output level, output out_of_range,
                   output line_done, output frame_done, input ready);
   modport sink   (input valid, input level, input out_of_range,
                   input line_done, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rbwn_front.sv =====
// Front stage: registers, raster counters, crop window, black pick, numerator setup.
`default_nettype none

module rbwn_front
   import rbwn_pkg::*;
#(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data,
   input  wire logic                      accept,
   input  wire logic                      advance,
   input  wire logic [15:0]               sample,
   input  wire logic                      start_of_frame,
   input  wire logic                      end_of_line,
   output logic                           valid_o,
   output ctl_type                        ctl_o,
   output logic [SAMPLE_BITS-1:0]         den_o,
   output logic [SAMPLE_BITS-1:0]         rem_o,
   output logic [QUO_BITS-1:0]            bits_o
);

   localparam int MAG_BITS = SAMPLE_BITS + FRACTION_BITS;
   localparam int NUM_BITS = (MAG_BITS + 1 > QUO_BITS + SAMPLE_BITS) ?
                             MAG_BITS + 1 : QUO_BITS + SAMPLE_BITS;
   localparam int TOP_BITS = NUM_BITS - QUO_BITS;

   logic [31:0]           black_even_ff, black_odd_ff;
   logic [15:0]           white_ff, crop_left_ff, crop_top_ff, out_width_ff, out_height_ff;
   logic [COUNT_BITS-1:0] column_ff, column_in, row_ff, row_in;

   logic [COUNT_BITS-1:0]  r, c, width_last, height_last;
   logic                   kept, line_end, frame_end;
   logic [31:0]            word;
   logic [15:0]            half;
   logic [SAMPLE_BITS-1:0] s, b, w, diff, den;
   logic                   neg, empty, over;
   logic [NUM_BITS-1:0]    mag, adj, num;
   logic [TOP_BITS-1:0]    rem0;

   logic                   valid_ff;
   ctl_type                ctl_ff;
   logic [SAMPLE_BITS-1:0] den_ff, rem_ff;
   logic [QUO_BITS-1:0]    bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         black_even_ff <= '0;
         black_odd_ff  <= '0;
         white_ff      <= 16'hFFFF;
         crop_left_ff  <= '0;
         crop_top_ff   <= '0;
         out_width_ff  <= 16'hFFFF;
         out_height_ff <= 16'hFFFF;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_BLACK_EVEN:  black_even_ff <= csr_write_data;
            CSR_BLACK_ODD:   black_odd_ff  <= csr_write_data;
            CSR_WHITE_LEVEL: white_ff      <= csr_write_data[15:0];
            CSR_CROP_LEFT:   crop_left_ff  <= csr_write_data[15:0];
            CSR_CROP_TOP:    crop_top_ff   <= csr_write_data[15:0];
            CSR_OUT_WIDTH:   out_width_ff  <= csr_write_data[15:0];
            CSR_OUT_HEIGHT:  out_height_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      r = start_of_frame ? '0 : row_ff;
      c = start_of_frame ? '0 : column_ff;

      width_last  = out_width_ff - 1'b1;
      height_last = out_height_ff - 1'b1;
      kept = (r >= crop_top_ff) && ((r - crop_top_ff) < out_height_ff) &&
             (c >= crop_left_ff) && ((c - crop_left_ff) < out_width_ff);
      line_end  = end_of_line || ((c - crop_left_ff) == width_last);
      frame_end = line_end && ((r - crop_top_ff) == height_last);

      word = r[0] ? black_odd_ff : black_even_ff;
      half = c[0] ? word[31:16] : word[15:0];
      b = half[SAMPLE_BITS-1:0];
      s = sample[SAMPLE_BITS-1:0];
      w = white_ff[SAMPLE_BITS-1:0];

      empty = (w <= b);
      neg   = (s < b);
      diff  = neg ? (b - s) : (s - b);
      den   = w - b;

      mag  = NUM_BITS'(diff) << FRACTION_BITS;
      adj  = neg ? NUM_BITS'(den - 1'b1) : '0;
      num  = mag + adj;
      rem0 = num[NUM_BITS-1:QUO_BITS];
      over = (rem0 >= TOP_BITS'(den));

      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (end_of_line) begin
            column_in = '0;
            row_in    = (r < COUNT_MAX) ? r + 1'b1 : r;
         end else begin
            column_in = (c < COUNT_MAX) ? c + 1'b1 : c;
            row_in    = r;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         valid_ff  <= 1'b0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         if (advance) begin
            valid_ff <= accept && kept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff.neg        <= neg;
         ctl_ff.empty      <= empty;
         ctl_ff.over       <= over;
         ctl_ff.line_done  <= line_end;
         ctl_ff.frame_done <= frame_end;
         den_ff            <= den;
         rem_ff            <= rem0[SAMPLE_BITS-1:0];
         bits_ff           <= num[QUO_BITS-1:0];
      end
   end

   assign valid_o = valid_ff;
   assign ctl_o   = ctl_ff;
   assign den_o   = den_ff;
   assign rem_o   = rem_ff;
   assign bits_o  = bits_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rbwn_cell.sv =====
// Divider cell: one restoring step, produces one quotient bit per stage.
`default_nettype none

module rbwn_cell
   import rbwn_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   valid_i,
   input  wire ctl_type                ctl_i,
   input  wire logic [SAMPLE_BITS-1:0] den_i,
   input  wire logic [SAMPLE_BITS-1:0] rem_i,
   input  wire logic [QUO_BITS-1:0]    bits_i,
   output logic                        valid_o,
   output ctl_type                     ctl_o,
   output logic [SAMPLE_BITS-1:0]      den_o,
   output logic [SAMPLE_BITS-1:0]      rem_o,
   output logic [QUO_BITS-1:0]         bits_o
);

   logic [SAMPLE_BITS:0]   t, t_sub;
   logic                   ge;
   logic [SAMPLE_BITS-1:0] rem_in;
   logic [QUO_BITS-1:0]    bits_in;

   logic                   valid_ff;
   ctl_type                ctl_ff;
   logic [SAMPLE_BITS-1:0] den_ff, rem_ff;
   logic [QUO_BITS-1:0]    bits_ff;

   always_comb begin
      t       = {rem_i, bits_i[QUO_BITS-1]};
      t_sub   = t - {1'b0, den_i};
      ge      = (t >= {1'b0, den_i});
      rem_in  = ge ? t_sub[SAMPLE_BITS-1:0] : t[SAMPLE_BITS-1:0];
      bits_in = {bits_i[QUO_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff  <= ctl_i;
         den_ff  <= den_i;
         rem_ff  <= rem_in;
         bits_ff <= bits_in;
      end
   end

   assign valid_o = valid_ff;
   assign ctl_o   = ctl_ff;
   assign den_o   = den_ff;
   assign rem_o   = rem_ff;
   assign bits_o  = bits_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rbwn_finish.sv =====
// Output stage: sign, saturation and empty-range handling into the response register.
`default_nettype none

module rbwn_finish
   import rbwn_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  valid_i,
   input  wire ctl_type               ctl_i,
   input  wire logic [QUO_BITS-1:0]   quo_i,
   output logic                       valid_o,
   output logic [LEVEL_BITS-1:0]      level_o,
   output logic                       flag_o,
   output logic                       line_done_o,
   output logic                       frame_done_o
);

   logic [QUO_BITS-1:0]   quo_neg;
   logic                  sat;
   logic [LEVEL_BITS-1:0] level_in;
   logic                  flag_in;

   logic                  valid_ff;
   logic [LEVEL_BITS-1:0] level_ff;
   logic                  flag_ff, line_ff, frame_ff;

   always_comb begin
      quo_neg = '0 - quo_i;
      if (ctl_i.empty) begin
         sat      = 1'b0;
         level_in = '0;
         flag_in  = 1'b1;
      end else if (ctl_i.neg) begin
         sat      = ctl_i.over || (quo_i > NEG_LIMIT);
         level_in = sat ? LEVEL_MIN_CODE : quo_neg[LEVEL_BITS-1:0];
         flag_in  = sat;
      end else begin
         sat      = ctl_i.over || (quo_i > POS_LIMIT);
         level_in = sat ? LEVEL_MAX_CODE : quo_i[LEVEL_BITS-1:0];
         flag_in  = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         level_ff <= level_in;
         flag_ff  <= flag_in;
         line_ff  <= ctl_i.line_done;
         frame_ff <= ctl_i.frame_done;
      end
   end

   assign valid_o      = valid_ff;
   assign level_o      = level_ff;
   assign flag_o       = flag_ff;
   assign line_done_o  = line_ff;
   assign frame_done_o = frame_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/raw_black_white_normalize.sv =====
// Top level: raw Bayer black level / white point normalization with crop window.
//
//   channel   direction  handshake      payload
//   req_chan  in         valid/ready    sample, start_of_frame, end_of_line
//   rsp_chan  out        valid/ready    level, out_of_range, line_done, frame_done
//   csr_*     in         write enable   csr_index, csr_write_data
//
// One request per cycle is taken while the chain is not held; a kept pixel passes through
// the front stage, 21 divider cells one quotient bit each, and the output register.
// Dropped pixels produce no response. Reset loads register defaults, clears
// the counters and empties the pipeline. While a response waits on rsp_chan
// the whole chain holds and req_chan.ready is low.
`default_nettype none

module raw_black_white_normalize
   import rbwn_pkg::*;
#(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   rbwn_req_if.sink                       req_chan,
   rbwn_rsp_if.source                     rsp_chan,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   logic                   advance, accept, rsp_valid;
   logic [LEVEL_BITS-1:0]  level;

   logic                   valid_d [QUO_BITS+1];
   ctl_type                ctl_d   [QUO_BITS+1];
   logic [SAMPLE_BITS-1:0] den_d   [QUO_BITS+1];
   logic [SAMPLE_BITS-1:0] rem_d   [QUO_BITS+1];
   logic [QUO_BITS-1:0]    bits_d  [QUO_BITS+1];

   assign advance        = !rsp_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   rbwn_front #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .advance          (advance),
      .sample           (req_chan.sample),
      .start_of_frame   (req_chan.start_of_frame),
      .end_of_line      (req_chan.end_of_line),
      .valid_o          (valid_d[0]),
      .ctl_o            (ctl_d[0]),
      .den_o            (den_d[0]),
      .rem_o            (rem_d[0]),
      .bits_o           (bits_d[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      rbwn_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (valid_d[i]),
         .ctl_i   (ctl_d[i]),
         .den_i   (den_d[i]),
         .rem_i   (rem_d[i]),
         .bits_i  (bits_d[i]),
         .valid_o (valid_d[i+1]),
         .ctl_o   (ctl_d[i+1]),
         .den_o   (den_d[i+1]),
         .rem_o   (rem_d[i+1]),
         .bits_o  (bits_d[i+1])
      );
   end

   rbwn_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .valid_i      (valid_d[QUO_BITS]),
      .ctl_i        (ctl_d[QUO_BITS]),
      .quo_i        (bits_d[QUO_BITS]),
      .valid_o      (rsp_valid),
      .level_o      (level),
      .flag_o       (rsp_chan.out_of_range),
      .line_done_o  (rsp_chan.line_done),
      .frame_done_o (rsp_chan.frame_done)
   );

   assign rsp_chan.valid = rsp_valid;
   assign rsp_chan.level = $signed(level);

endmodule

`default_nettype wire

// ===== verif/raw_black_white_normalize_test.sv =====
`timescale 1ns / 100ps
// Testbench for raw_black_white_normalize: framed pixel requests checked against a local predictor.
module raw_black_white_normalize_test
   import rbwn_pkg::*;
;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int FRACTION_BITS = 16;
   localparam longint LEVEL_HIGH = 524287;
   localparam longint LEVEL_LOW  = -524288;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef struct packed {
      logic [15:0] sample;
      logic        sof;
      logic        eol;
   } pixel_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic                  out_of_range;
      logic                  line_done;
      logic                  frame_done;
   } level_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   rbwn_req_if req_chan ();
   rbwn_rsp_if rsp_chan ();

   raw_black_white_normalize u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the registers and counters
   bit [31:0] black_even = '0;
   bit [31:0] black_odd  = '0;
   bit [15:0] white_level = 16'hFFFF;
   bit [15:0] crop_left  = '0;
   bit [15:0] crop_top   = '0;
   bit [15:0] out_width  = 16'hFFFF;
   bit [15:0] out_height = 16'hFFFF;
   bit [15:0] col_count  = '0;
   bit [15:0] row_count  = '0;

   pixel_type pixel_queue[$];
   level_type level_queue[$];
   level_type predicted;
   level_type oldest;
   bit     steady = 1'b0;
   int     mismatch_count = 0;
   int     cycle_count = 0;

   always #HALF_PERIOD clock = ~clock;

   function automatic bit normalize_pixel(input pixel_type px, output level_type res);
      int r, c, top, left, width, height, blk, wht, s, den;
      longint q;
      bit [31:0] word;
      bit kept, flag;
      res = '0;
      if (px.sof) begin
         col_count = '0;
         row_count = '0;
      end
      r = row_count;
      c = col_count;
      top = crop_top;
      left = crop_left;
      width = out_width;
      height = out_height;
      kept = r >= top && r - top < height && c >= left && c - left < width;
      if (kept) begin
         word = r[0] ? black_odd : black_even;
         blk = c[0] ? word[31:16] : word[15:0];
         wht = white_level;
         s = px.sample;
         flag = 1'b0;
         q = 0;
         if (wht <= blk) begin
            flag = 1'b1;
         end else begin
            den = wht - blk;
            if (s >= blk)
               q = (longint'(s - blk) << FRACTION_BITS) / den;
            else
               q = -(((longint'(blk - s) << FRACTION_BITS) + den - 1) / den);
            if (q > LEVEL_HIGH) begin
               q = LEVEL_HIGH;
               flag = 1'b1;
            end
            if (q < LEVEL_LOW) begin
               q = LEVEL_LOW;
               flag = 1'b1;
            end
         end
         res.level = q[LEVEL_BITS-1:0];
         res.out_of_range = flag;
         res.line_done = px.eol || (c - left == width - 1);
         res.frame_done = res.line_done && (r - top == height - 1);
      end
      if (px.eol) begin
         col_count = '0;
         if (row_count < COUNT_MAX) row_count = row_count + 1'b1;
      end else if (col_count < COUNT_MAX) begin
         col_count = col_count + 1'b1;
      end
      return kept;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         CSR_BLACK_EVEN:  black_even = data;
         CSR_BLACK_ODD:   black_odd = data;
         CSR_WHITE_LEVEL: white_level = data[15:0];
         CSR_CROP_LEFT:   crop_left = data[15:0];
         CSR_CROP_TOP:    crop_top = data[15:0];
         CSR_OUT_WIDTH:   out_width = data[15:0];
         CSR_OUT_HEIGHT:  out_height = data[15:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] be, input logic [31:0] bo, input logic [15:0] w,
                            input logic [15:0] cl, input logic [15:0] ct,
                            input logic [15:0] ow, input logic [15:0] oh);
      write_reg(CSR_BLACK_EVEN, be);
      write_reg(CSR_BLACK_ODD, bo);
      write_reg(CSR_WHITE_LEVEL, {16'h0, w});
      write_reg(CSR_CROP_LEFT, {16'($urandom_range(0, 65535)), cl});
      write_reg(CSR_CROP_TOP, {16'h0, ct});
      write_reg(CSR_OUT_WIDTH, {16'h0, ow});
      write_reg(CSR_OUT_HEIGHT, {16'h0, oh});
   endtask

   // hold until every request is taken and every response has come
   task automatic settle();
      while (pixel_queue.size() != 0 || req_chan.valid || level_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_pixel(input logic [15:0] s, input logic sof, input logic eol);
      pixel_type px;
      px.sample = s;
      px.sof = sof;
      px.eol = eol;
      pixel_queue.push_back(px);
   endtask

   function automatic logic [15:0] pick_sample();
      int roll;
      logic [15:0] v;
      roll = $urandom_range(0, 9);
      v = 16'($urandom);
      if (roll == 0) v = 16'h0000;
      else if (roll == 1) v = 16'hFFFF;
      else if (roll < 5)
         v = 16'(($urandom_range(0, 1) ? white_level : black_even[15:0])
                 + $urandom_range(0, 512) - 256);
      return v;
   endfunction

   function automatic logic [15:0] pick_black();
      logic [15:0] v;
      v = 16'($urandom);
      if ($urandom_range(0, 99) < 80) v = 16'($urandom_range(0, 4095));
      return v;
   endfunction

   task automatic queue_frames(input int n_items);
      int count, rows, cols;
      pixel_type px;
      count = 0;
      while (count < n_items) begin
         rows = $urandom_range(1, 7);
         for (int y = 0; y < rows; y++) begin
            cols = $urandom_range(1, 14);
            for (int x = 0; x < cols; x++) begin
               px.sample = pick_sample();
               px.sof = (y == 0 && x == 0);
               px.eol = (x == cols - 1);
               if ($urandom_range(0, 99) < 6) px.sof = ~px.sof;
               if ($urandom_range(0, 99) < 6) px.eol = ~px.eol;
               pixel_queue.push_back(px);
               count++;
            end
         end
      end
   endtask

   task automatic program_random(input int phase);
      logic [31:0] be, bo;
      logic [15:0] w, cl, ct, ow, oh;
      int roll;
      be = {pick_black(), pick_black()};
      bo = {pick_black(), pick_black()};
      roll = $urandom_range(0, 99);
      w = 16'($urandom_range(1000, 65535));
      if (roll < 15) w = 16'hFFFF;
      else if (roll < 35) w = 16'(be[15:0] + $urandom_range(1, 40));
      cl = 16'($urandom_range(0, 3));
      ct = 16'($urandom_range(0, 2));
      ow = 16'($urandom_range(1, 10));
      oh = 16'($urandom_range(1, 5));
      if ($urandom_range(0, 9) == 0) ow = 16'hFFFF;
      if ($urandom_range(0, 9) == 0) oh = 16'hFFFF;
      if (phase == 0) w = 16'h0000;
      if (phase == 1) begin
         be = '1;
         bo = '1;
         w = 16'hFFFF;
      end
      configure(be, bo, w, cl, ct, ow, oh);
   endtask

   // request driver and predictor
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.sample <= '0;
         req_chan.start_of_frame <= 1'b0;
         req_chan.end_of_line <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (normalize_pixel({req_chan.sample, req_chan.start_of_frame,
                                 req_chan.end_of_line}, predicted))
               level_queue.push_back(predicted);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pixel_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
               req_chan.valid <= 1'b1;
               req_chan.sample <= pixel_queue[0].sample;
               req_chan.start_of_frame <= pixel_queue[0].sof;
               req_chan.end_of_line <= pixel_queue[0].eol;
               void'(pixel_queue.pop_front());
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= steady || $urandom_range(0, 99) >= 15;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (level_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected response, level %0d", rsp_chan.level));
         end else begin
            oldest = level_queue.pop_front();
            if (rsp_chan.level !== oldest.level)
               report_mismatch($sformatf("level %0d, predicted %0d",
                                         rsp_chan.level, $signed(oldest.level)));
            if (rsp_chan.out_of_range !== oldest.out_of_range)
               report_mismatch($sformatf("out_of_range %b, predicted %b",
                                         rsp_chan.out_of_range, oldest.out_of_range));
            if (rsp_chan.line_done !== oldest.line_done)
               report_mismatch($sformatf("line_done %b, predicted %b",
                                         rsp_chan.line_done, oldest.line_done));
            if (rsp_chan.frame_done !== oldest.frame_done)
               report_mismatch($sformatf("frame_done %b, predicted %b",
                                         rsp_chan.frame_done, oldest.frame_done));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_BLACK_EVEN;
      csr_write_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // register defaults
      add_pixel(16'h0000, 1'b1, 1'b0);
      add_pixel(16'hFFFF, 1'b0, 1'b0);
      add_pixel(16'h8000, 1'b0, 1'b1);
      add_pixel(16'h00FF, 1'b1, 1'b1);
      settle();

      // empty range, saturation both ways, short line
      configure(32'h0010_FFFF, 32'h7FFF_0000, 16'd17, 16'd0, 16'd0, 16'd3, 16'd2);
      write_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      add_pixel(16'd5, 1'b1, 1'b0);
      add_pixel(16'h0000, 1'b0, 1'b0);
      add_pixel(16'h5555, 1'b0, 1'b0);
      add_pixel(16'hAAAA, 1'b0, 1'b1);
      add_pixel(16'hFFFF, 1'b0, 1'b0);
      add_pixel(16'h0003, 1'b0, 1'b1);
      add_pixel(16'h1234, 1'b0, 1'b1);
      settle();

      // empty window
      configure(32'h0, 32'h0, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'd4);
      for (int i = 0; i < 6; i++) add_pixel(16'($urandom), i == 0, i % 3 == 2);
      settle();
      write_reg(CSR_OUT_WIDTH, 32'd4);
      write_reg(CSR_OUT_HEIGHT, 32'd0);
      for (int i = 0; i < 4; i++) add_pixel(16'($urandom), i == 0, i == 1);
      settle();

      for (int phase = 0; phase < 12; phase++) begin
         program_random(phase);
         steady = (phase == 2);
         queue_frames(125);
         settle();
         steady = 1'b0;
      end

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
